[hdl/sec_pkg.sv]
package sec_pkg;

	localparam int WORD_WIDTH = 16;
	localparam int CNT_W      = $clog2(WORD_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

	localparam logic [7:0] CH_SEP  = 8'h3B;
	localparam logic [7:0] CH_END  = 8'h26;
	localparam logic [7:0] CH_ADD  = 8'h2B;
	localparam logic [7:0] CH_SUB  = 8'h2D;
	localparam logic [7:0] CH_MUL  = 8'h2A;
	localparam logic [7:0] CH_DIV  = 8'h2F;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef logic [WORD_WIDTH-1:0] word_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BAD_OP = 2'd1,
		STAT_BAD_DIV = 2'd2,
		STAT_NO_SEP = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_LEFT,
		S_OPER,
		S_RIGHT,
		S_CALC,
		S_ABORT,
		S_LOAD
	} state_t;

	typedef struct packed {
		logic push_left;
		logic push_right;
		logic set_op;
		logic start;
		logic step;
		logic load_calc;
		logic load_abort;
	} cmd_t;

	typedef struct packed {
		logic is_end;
		logic is_sep;
		logic calc_done;
		logic out_free;
	} sts_t;

	function automatic logic [15:0] to_out16(word_t v);
		logic [31:0] t;
		t = 32'(v);
		return t[15:0];
	endfunction

endpackage

[hdl/sec_ctrl.sv]
module sec_ctrl import sec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LEFT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LEFT: begin
				if (accept) begin
					if (sts.is_end) begin
						state_d = S_ABORT;
					end else if (sts.is_sep) begin
						state_d = S_OPER;
					end
				end
			end
			S_OPER: begin
				if (accept) begin
					state_d = sts.is_end ? S_CALC : S_RIGHT;
				end
			end
			S_RIGHT: begin
				if (accept && sts.is_end) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				if (sts.calc_done) begin
					state_d = S_LOAD;
				end
			end
			S_ABORT, S_LOAD: begin
				if (sts.out_free) begin
					state_d = S_LEFT;
				end
			end
			default: state_d = S_LEFT;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_LEFT: begin
				in_ready       = 1'b1;
				cmd.push_left  = in_valid && !sts.is_end && !sts.is_sep;
			end
			S_OPER: begin
				in_ready   = 1'b1;
				cmd.set_op = in_valid;
				cmd.start  = in_valid && sts.is_end;
			end
			S_RIGHT: begin
				in_ready       = 1'b1;
				cmd.push_right = in_valid && !sts.is_end;
				cmd.start      = in_valid && sts.is_end;
			end
			S_CALC: begin
				cmd.step = 1'b1;
			end
			S_ABORT: begin
				cmd.load_abort = sts.out_free;
			end
			S_LOAD: begin
				cmd.load_calc = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[hdl/sec_dp.sv]
module sec_dp import sec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] answer,
	output logic [15:0] left_operand,
	output logic [7:0]  operator_char,
	output logic [15:0] right_operand,
	output logic [1:0]  status
);

	word_t            left_q, right_q, x_q, y_q, r_q;
	logic [7:0]       op_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [15:0]      ans_q, left_out_q, right_out_q;
	logic [7:0]       op_out_q;
	status_t          stat_q;

	logic [3:0]       digit;
	word_t            base_acc, pushed;
	logic [WORD_WIDTH:0] trial;
	logic             fits;
	word_t            res_ans;
	status_t          res_stat;
	logic             b_nonpos;

	always_comb begin
		if (rx_byte inside {[CH_ZERO:CH_NINE]}) begin
			digit = 4'(rx_byte - CH_ZERO);
		end else begin
			digit = 4'd0;
		end
		base_acc = cmd.push_right ? right_q : left_q;
		pushed   = (base_acc << 3) + (base_acc << 1) + WORD_WIDTH'(digit);
	end

	assign trial = {r_q, y_q[WORD_WIDTH-1]};
	assign fits  = trial >= {1'b0, right_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
			op_q    <= '0;
		end else if (cmd.load_calc || cmd.load_abort) begin
			left_q  <= '0;
			right_q <= '0;
			op_q    <= '0;
		end else begin
			if (cmd.push_left) begin
				left_q <= pushed;
			end
			if (cmd.push_right) begin
				right_q <= pushed;
			end
			if (cmd.set_op) begin
				op_q <= rx_byte;
			end
		end
	end

	// iterate: shift-add multiply or restoring divide, one bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cnt_q <= '0;
			x_q   <= left_q;
			y_q   <= (op_q == CH_DIV) ? left_q : right_q;
			r_q   <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
			if (op_q == CH_DIV) begin
				r_q <= fits ? WORD_WIDTH'(trial - {1'b0, right_q}) : trial[WORD_WIDTH-1:0];
				y_q <= {y_q[WORD_WIDTH-2:0], fits};
			end else begin
				if (y_q[0]) begin
					r_q <= r_q + x_q;
				end
				x_q <= x_q << 1;
				y_q <= y_q >> 1;
			end
		end
	end

	assign b_nonpos = right_q[WORD_WIDTH-1] || (right_q == '0);

	always_comb begin
		res_ans  = '0;
		res_stat = STAT_OK;
		case (op_q)
			CH_ADD: res_ans = left_q + right_q;
			CH_SUB: res_ans = left_q - right_q;
			CH_MUL: res_ans = b_nonpos ? '0 : r_q;
			CH_DIV: begin
				if (b_nonpos) begin
					res_stat = STAT_BAD_DIV;
				end else if (!left_q[WORD_WIDTH-1]) begin
					res_ans = y_q;
				end
			end
			default: res_stat = STAT_BAD_OP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_calc || cmd.load_abort) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_calc || cmd.load_abort) begin
			ans_q       <= cmd.load_abort ? 16'd0 : to_out16(res_ans);
			stat_q      <= cmd.load_abort ? STAT_NO_SEP : res_stat;
			left_out_q  <= to_out16(left_q);
			right_out_q <= to_out16(right_q);
			op_out_q    <= op_q;
		end
	end

	always_comb begin
		sts.is_end    = rx_byte == CH_END;
		sts.is_sep    = rx_byte == CH_SEP;
		sts.calc_done = cmd.step && (cnt_q == CNT_LAST);
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign answer        = ans_q;
	assign left_operand  = left_out_q;
	assign operator_char = op_out_q;
	assign right_operand = right_out_q;
	assign status        = stat_q;

endmodule

[hdl/serial_expression_calculator_unit.sv]
// Serial expression calculator: takes one received byte per beat on the slave stream
// (frames of digits ';' operator digits '&') and returns one result beat per closing '&'.
// Digit, separator and operator bytes are taken as they arrive. A closing '&' after the
// separator is accepted, then the shared shift-add multiply / restoring divide unit runs
// one iteration per operand bit, then the output register is loaded. A '&' before the
// separator skips the iterations. Input is held off during the iterations and while the
// output register is still full at load time; a waiting result does not stop the byte
// parse.
module serial_expression_calculator_unit import sec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [15:0] answer, [31:16] left_operand,
	                               // [39:32] operator_char, [55:40] right_operand,
	                               // [57:56] status, [63:58] zero
);

	cmd_t        cmd;
	sts_t        sts;
	logic [15:0] answer, left_operand, right_operand;
	logic [7:0]  operator_char;
	logic [1:0]  status;

	sec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sec_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (s_tdata),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.answer        (answer),
		.left_operand  (left_operand),
		.operator_char (operator_char),
		.right_operand (right_operand),
		.status        (status)
	);

	assign m_tdata = {6'd0, status, right_operand, operator_char, left_operand, answer};

endmodule
